[sv/set_assoc_page_map_fifo_defines.svh]
// assertion macros for the set associative page map
`ifndef SET_ASSOC_PAGE_MAP_FIFO_DEFINES_SVH
`define SET_ASSOC_PAGE_MAP_FIFO_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SAPM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define SAPM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/sapm_pkg.sv]
// shared types and constants of the set associative page map
`default_nettype none

package sapm_pkg;

	localparam int unsigned ADDR_W      = 64;
	localparam int unsigned IN_PAY_W    = 32;
	localparam int unsigned OUT_PAY_W   = 32;
	localparam int unsigned WAY_OUT_W   = 2;
	localparam int unsigned DIGIT_W     = 16;
	localparam int unsigned SET_STEPS   = 2 * ADDR_W / DIGIT_W;
	localparam int unsigned STEP_CNT_W  = 4;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_COMPARE
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic rd;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic calc_done;
		logic out_free;
	} ctrl_stat_t;

endpackage

`default_nettype wire

[sv/set_assoc_page_map_fifo.sv]
// top level of the set associative page map with round-robin replacement
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | to block  | in_valid / in_stall | command, addr, payload_in
//  out     | from block| out_valid/out_stall | hit, way_used, payload_out
//
// one transaction at a time: accept, set read, compare and write back when SETS is a power of two;
// otherwise the set index first takes 8 reciprocal steps on 16-bit address digits
// after reset a clearing pass writes every set row, with in_stall held high
// the result register frees the datapath: a new transaction is accepted while a result waits
// a stalled result holds the final compare stage until the output register is free
`default_nettype none

module set_assoc_page_map_fifo #(
	parameter int unsigned SETS          = 256,
	parameter int unsigned WAYS          = 4,
	parameter int unsigned PAYLOAD_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              command,
	input  wire logic [sapm_pkg::ADDR_W-1:0]       addr,
	input  wire logic [sapm_pkg::IN_PAY_W-1:0]     payload_in,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   hit,
	output logic      [sapm_pkg::WAY_OUT_W-1:0]    way_used,
	output logic      [sapm_pkg::OUT_PAY_W-1:0]    payload_out
);

	sapm_pkg::ctrl_cmd_t  cmd;
	sapm_pkg::ctrl_stat_t st;

	sapm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	sapm_datapath #(
		.SETS          (SETS),
		.WAYS          (WAYS),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.command     (command),
		.addr        (addr),
		.payload_in  (payload_in),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.hit         (hit),
		.way_used    (way_used),
		.payload_out (payload_out)
	);

endmodule

`default_nettype wire

[sv/sapm_ram.sv]
// generic single write port memory with registered read
`default_nettype none

module sapm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic                                          re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic      [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[sv/sapm_set_index.sv]
// set index from address, 16-bit digit reciprocal remainder when set count is not a power of two
`default_nettype none

module sapm_set_index #(
	parameter int unsigned SETS = 256
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        load,
	input  wire logic [sapm_pkg::ADDR_W-1:0]                 addr,
	output logic      [((SETS > 1) ? $clog2(SETS) : 1)-1:0]  set_idx,
	output logic                                             done
);

	localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam bit POW2 = ((SETS & (SETS - 1)) == 0);

	generate
		if (POW2) begin : g_pow2
			logic [SET_W-1:0] set_q;
			logic             done_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else if (load) begin
					done_q <= 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				if (load) begin
					set_q <= addr[SET_W-1:0] & SET_W'(SETS - 1);
				end
			end

			assign set_idx = set_q;
			assign done    = done_q;
		end else begin : g_recip
			localparam int unsigned DW     = sapm_pkg::DIGIT_W;
			localparam int unsigned SHIFT  = 2 * DW + SET_W;
			localparam int unsigned MAG_W  = 2 * DW + 1;
			localparam int unsigned PROD_W = 4 * DW + 1;
			localparam logic [MAG_W-1:0] MAGIC =
				MAG_W'(((64'd1 << SHIFT) + 64'(SETS) - 64'd1) / 64'(SETS));

			logic [sapm_pkg::STEP_CNT_W-1:0] cnt_q;
			logic [sapm_pkg::ADDR_W-1:0]     sh_q;
			logic [DW-1:0]                   rem_q;
			logic [DW-1:0]                   dig_q;
			logic [DW-1:0]                   quo_q;
			logic [2*DW-1:0]                 num;
			logic [PROD_W-1:0]               prod;

			// remainder so far followed by the next address digit, msb first
			assign num  = {rem_q, sh_q[sapm_pkg::ADDR_W-1 -: DW]};
			assign prod = PROD_W'(num) * PROD_W'(MAGIC);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q <= '0;
				end else if (load) begin
					cnt_q <= sapm_pkg::STEP_CNT_W'(sapm_pkg::SET_STEPS);
				end else if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end

			// even step: quotient by reciprocal, odd step: remainder from low quotient bits
			always_ff @(posedge clk) begin
				if (load) begin
					sh_q  <= addr;
					rem_q <= '0;
				end else if (cnt_q != '0) begin
					if (!cnt_q[0]) begin
						quo_q <= prod[SHIFT +: DW];
						dig_q <= sh_q[sapm_pkg::ADDR_W-1 -: DW];
						sh_q  <= {sh_q[sapm_pkg::ADDR_W-DW-1:0], {DW{1'b0}}};
					end else begin
						rem_q <= dig_q - DW'(quo_q * DW'(SETS));
					end
				end
			end

			assign set_idx = rem_q[SET_W-1:0];
			assign done    = (cnt_q == '0);
		end
	endgenerate

endmodule

`default_nettype wire

[sv/sapm_datapath.sv]
// datapath: item registers, set memory, way compare, row update and result register
`default_nettype none

`include "set_assoc_page_map_fifo_defines.svh"

module sapm_datapath #(
	parameter int unsigned SETS          = 256,
	parameter int unsigned WAYS          = 4,
	parameter int unsigned PAYLOAD_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sapm_pkg::ctrl_cmd_t               cmd,
	output sapm_pkg::ctrl_stat_t                   st,
	input  wire logic                              command,
	input  wire logic [sapm_pkg::ADDR_W-1:0]       addr,
	input  wire logic [sapm_pkg::IN_PAY_W-1:0]     payload_in,
	input  wire logic                              out_stall,
	output logic                                   out_valid,
	output logic                                   hit,
	output logic      [sapm_pkg::WAY_OUT_W-1:0]    way_used,
	output logic      [sapm_pkg::OUT_PAY_W-1:0]    payload_out
);

	localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned PTR_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned ENT_W = 1 + sapm_pkg::ADDR_W + PAYLOAD_WIDTH;
	localparam int unsigned ROW_W = WAYS * ENT_W + PTR_W;

	logic                                 cmd_q;
	logic [sapm_pkg::ADDR_W-1:0]          addr_q;
	logic [PAYLOAD_WIDTH-1:0]             pay_q;
	logic [SET_W-1:0]                     clr_q;
	logic [SET_W-1:0]                     set_idx;
	logic                                 calc_done;
	logic                                 ram_we;
	logic [SET_W-1:0]                     ram_waddr;
	logic [ROW_W-1:0]                     ram_wdata;
	logic [ROW_W-1:0]                     row;
	logic [ROW_W-1:0]                     new_row;
	logic                                 found;
	logic [PTR_W-1:0]                     hit_way;
	logic [PAYLOAD_WIDTH-1:0]             hit_pay;
	logic [PTR_W-1:0]                     victim;
	logic [PTR_W-1:0]                     tgt;
	logic                                 out_valid_q;
	logic                                 hit_q;
	logic [sapm_pkg::WAY_OUT_W-1:0]       way_q;
	logic [sapm_pkg::OUT_PAY_W-1:0]       pay_out_q;

	sapm_set_index #(
		.SETS (SETS)
	) u_set_index (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (cmd.load),
		.addr    (addr),
		.set_idx (set_idx),
		.done    (calc_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= command;
			addr_q <= addr;
			pay_q  <= PAYLOAD_WIDTH'(payload_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	sapm_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd),
		.raddr (set_idx),
		.rdata (row)
	);

	// lowest matching way wins
	always_comb begin
		found   = 1'b0;
		hit_way = '0;
		hit_pay = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row[w * ENT_W + PAYLOAD_WIDTH + sapm_pkg::ADDR_W]
			    && (row[w * ENT_W + PAYLOAD_WIDTH +: sapm_pkg::ADDR_W] == addr_q)) begin
				found   = 1'b1;
				hit_way = PTR_W'(w);
				hit_pay = row[w * ENT_W +: PAYLOAD_WIDTH];
			end
		end
	end

	assign victim = row[WAYS * ENT_W +: PTR_W];
	assign tgt    = found ? hit_way : victim;

	always_comb begin
		new_row = row;
		for (int w = 0; w < WAYS; w++) begin
			if (PTR_W'(w) == tgt) begin
				new_row[w * ENT_W +: ENT_W] = {1'b1, addr_q, pay_q};
			end
		end
		if (!found) begin
			if (victim == PTR_W'(WAYS - 1)) begin
				new_row[WAYS * ENT_W +: PTR_W] = '0;
			end else begin
				new_row[WAYS * ENT_W +: PTR_W] = victim + 1'b1;
			end
		end
	end

	assign ram_we    = cmd.clear || (cmd.finish && (cmd_q == sapm_pkg::CMD_INSERT));
	assign ram_waddr = cmd.clear ? clr_q : set_idx;
	assign ram_wdata = cmd.clear ? '0 : new_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			hit_q <= found;
			if (found) begin
				way_q <= sapm_pkg::WAY_OUT_W'(hit_way);
			end else if (cmd_q == sapm_pkg::CMD_INSERT) begin
				way_q <= sapm_pkg::WAY_OUT_W'(victim);
			end else begin
				way_q <= '0;
			end
			if (found && (cmd_q == sapm_pkg::CMD_LOOKUP)) begin
				pay_out_q <= sapm_pkg::OUT_PAY_W'(hit_pay);
			end else begin
				pay_out_q <= '0;
			end
		end
	end

	assign st.clear_last = (clr_q == SET_W'(SETS - 1));
	assign st.calc_done  = calc_done;
	assign st.out_free   = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign way_used    = way_q;
	assign payload_out = pay_out_q;

	`SAPM_ASSERT_NXT(a_finish_loads_out, cmd.finish, out_valid_q, "result not presented after finish")
	`SAPM_ASSERT_IMP(a_pay_needs_hit, out_valid_q && (pay_out_q != '0), hit_q, "payload returned without hit")

endmodule

`default_nettype wire

[sv/sapm_ctrl.sv]
// controller state machine: clear pass, accept, set index, read, compare and write back
`default_nettype none

`include "set_assoc_page_map_fifo_defines.svh"

module sapm_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire sapm_pkg::ctrl_stat_t  st,
	output sapm_pkg::ctrl_cmd_t        cmd
);

	sapm_pkg::state_t state_q;
	sapm_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sapm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sapm_pkg::ST_CLEAR: begin
				if (st.clear_last) begin
					state_nxt = sapm_pkg::ST_IDLE;
				end
			end
			sapm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = sapm_pkg::ST_CALC;
				end
			end
			sapm_pkg::ST_CALC: begin
				if (st.calc_done) begin
					state_nxt = sapm_pkg::ST_COMPARE;
				end
			end
			sapm_pkg::ST_COMPARE: begin
				if (st.out_free) begin
					state_nxt = sapm_pkg::ST_IDLE;
				end
			end
			default: state_nxt = sapm_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd        = '0;
		in_stall   = 1'b1;
		unique case (state_q)
			sapm_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			sapm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			sapm_pkg::ST_CALC: begin
				cmd.rd = st.calc_done;
			end
			sapm_pkg::ST_COMPARE: begin
				cmd.finish = st.out_free;
			end
			default: cmd = '0;
		endcase
	end

	`SAPM_ASSERT_NXT(a_rd_then_compare, cmd.rd, state_q == sapm_pkg::ST_COMPARE, "read not followed by compare")
	`SAPM_ASSERT_NXT(a_load_then_calc, cmd.load, cmd.clear == 1'b0 && in_stall, "busy after transaction accepted")
	`SAPM_ASSERT_IMP(a_finish_free, cmd.finish, st.out_free && !cmd.rd, "finish with output slot busy")

endmodule

`default_nettype wire
